### rtl/anchored_tile_splitter_top_assert.svh
`ifndef ANCHORED_TILE_SPLITTER_TOP_ASSERT_SVH
`define ANCHORED_TILE_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ATS_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ATS_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ats_pkg.sv
package ats_pkg;

	localparam int COORD_W   = 20;
	localparam int LIMIT_W   = 7;
	localparam int TEX_W     = 13;
	localparam int TEX_FRAC  = 12;
	localparam int POS_W     = 22;
	localparam int NUM_LANES = 4;
	localparam int DIV_W     = 28;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = DIV_W / DIV_BITS;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [TEX_W-1:0] TEX_ONE = 13'd4096;

	// Divider lane assignment
	localparam int LANE_MIN_X = 0;
	localparam int LANE_MIN_Y = 1;
	localparam int LANE_MAX_X = 2;
	localparam int LANE_MAX_Y = 3;

	typedef struct packed {
		logic signed [COORD_W-1:0] area_min_x;
		logic signed [COORD_W-1:0] area_min_y;
		logic signed [COORD_W-1:0] area_max_x;
		logic signed [COORD_W-1:0] area_max_y;
		logic signed [COORD_W-1:0] grid_origin_x;
		logic signed [COORD_W-1:0] grid_origin_y;
		logic [LIMIT_W-1:0]        tile_limit;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] clip_x0;
		logic signed [COORD_W-1:0] clip_y0;
		logic signed [COORD_W-1:0] clip_x1;
		logic signed [COORD_W-1:0] clip_y1;
		logic [TEX_W-1:0]          tex_u0;
		logic [TEX_W-1:0]          tex_v0;
		logic [TEX_W-1:0]          tex_u1;
		logic [TEX_W-1:0]          tex_v1;
		logic                      last_tile;
		logic                      empty_area;
	} out_t;

	typedef struct packed {
		logic load;
		logic start_rem;
		logic cap_rem;
		logic start_tex;
		logic cap_tex;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic div_done;
		logic tile_fire;
		logic tile_last;
	} sts_t;

	typedef logic [NUM_LANES-1:0][DIV_W-1:0] div_word_t;

	function automatic logic signed [POS_W-1:0] sext(input logic signed [COORD_W-1:0] v);
		return {{(POS_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

endpackage

### rtl/ats_ifs.sv
interface ats_in_if;
	import ats_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] area_min_x;
	logic signed [COORD_W-1:0] area_min_y;
	logic signed [COORD_W-1:0] area_max_x;
	logic signed [COORD_W-1:0] area_max_y;
	logic signed [COORD_W-1:0] grid_origin_x;
	logic signed [COORD_W-1:0] grid_origin_y;
	logic [LIMIT_W-1:0]        tile_limit;

	modport source (output valid, area_min_x, area_min_y, area_max_x, area_max_y,
		grid_origin_x, grid_origin_y, tile_limit, input ready);
	modport sink (input valid, area_min_x, area_min_y, area_max_x, area_max_y,
		grid_origin_x, grid_origin_y, tile_limit, output ready);
endinterface

interface ats_out_if;
	import ats_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] clip_x0;
	logic signed [COORD_W-1:0] clip_y0;
	logic signed [COORD_W-1:0] clip_x1;
	logic signed [COORD_W-1:0] clip_y1;
	logic [TEX_W-1:0]          tex_u0;
	logic [TEX_W-1:0]          tex_v0;
	logic [TEX_W-1:0]          tex_u1;
	logic [TEX_W-1:0]          tex_v1;
	logic                      last_tile;
	logic                      empty_area;

	modport source (output valid, clip_x0, clip_y0, clip_x1, clip_y1, tex_u0, tex_v0,
		tex_u1, tex_v1, last_tile, empty_area, input ready);
	modport sink (input valid, clip_x0, clip_y0, clip_x1, clip_y1, tex_u0, tex_v0,
		tex_u1, tex_v1, last_tile, empty_area, output ready);
endinterface

### rtl/ats_div.sv
module ats_div #(
	parameter int unsigned DIVISOR = 1024,
	parameter int unsigned REM_W   = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  ats_pkg::div_word_t                    dividend,
	output logic                                  done,
	output ats_pkg::div_word_t                    quot,
	output logic [ats_pkg::NUM_LANES-1:0][REM_W-1:0] rem
);
	import ats_pkg::*;

	localparam logic [REM_W-1:0] DIVISOR_R = REM_W'(DIVISOR);

	div_word_t                        q_q;
	logic [NUM_LANES-1:0][REM_W-1:0]  r_q;
	div_word_t                        q_nx;
	logic [NUM_LANES-1:0][REM_W-1:0]  r_nx;
	logic [STEP_W-1:0]                step_q;
	logic                             busy_q;
	logic                             done_q;

	// Four restoring steps per cycle on every lane
	always_comb begin
		logic [DIV_W-1:0] q_t;
		logic [REM_W-1:0] r_t;
		q_nx = q_q;
		r_nx = r_q;
		for (int l = 0; l < NUM_LANES; l++) begin
			q_t = q_q[l];
			r_t = r_q[l];
			for (int b = 0; b < DIV_BITS; b++) begin
				r_t = {r_t[REM_W-2:0], q_t[DIV_W-1]};
				q_t = {q_t[DIV_W-2:0], 1'b0};
				if (r_t >= DIVISOR_R) begin
					r_t    = r_t - DIVISOR_R;
					q_t[0] = 1'b1;
				end
			end
			q_nx[l] = q_t;
			r_nx[l] = r_t;
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load or advance the partial quotient and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= q_nx;
			r_q <= r_nx;
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

### rtl/ats_dp.sv
`include "anchored_tile_splitter_top_assert.svh"

module ats_dp #(
	parameter int unsigned TILE_SIZE = 1024,
	parameter int unsigned MAX_TILES = 64,
	parameter int unsigned REM_W     = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ats_pkg::cmd_t cmd,
	output ats_pkg::sts_t sts,
	input  ats_pkg::in_t  in_data,
	output ats_pkg::out_t out_data,
	output logic          out_valid,
	input  logic          out_ready
);
	import ats_pkg::*;

	localparam logic signed [POS_W-1:0] T_POS  = POS_W'(TILE_SIZE);
	localparam logic [TEX_W-1:0]        T_OFF  = TEX_W'(TILE_SIZE);
	localparam logic [TEX_FRAC-1:0]     T_HALF = TEX_FRAC'(TILE_SIZE / 2);
	localparam logic [LIMIT_W-1:0]      LIM_MAX = LIMIT_W'(MAX_TILES);

	in_t                               in_q;
	logic [LIMIT_W-1:0]                lim_q;
	logic                              empty_q;
	logic [NUM_LANES-1:0]              neg_q;
	logic [NUM_LANES-1:0][TEX_W-1:0]   off_q;
	logic [NUM_LANES-1:0][TEX_W-1:0]   tex_q;
	logic signed [POS_W-1:0]           first_x_q;
	logic signed [POS_W-1:0]           first_y_q;
	logic signed [POS_W-1:0]           tx_q;
	logic signed [POS_W-1:0]           ty_q;
	logic                              col_first_q;
	logic                              row_first_q;
	logic [LIMIT_W-1:0]                count_q;
	out_t                              out_q;
	logic                              out_valid_q;

	logic signed [POS_W-1:0]           diff [NUM_LANES];
	logic [NUM_LANES-1:0][POS_W-1:0]   mag;
	logic [NUM_LANES-1:0][TEX_W-1:0]   fmod;
	div_word_t                         div_in;
	div_word_t                         div_quot;
	logic [NUM_LANES-1:0][REM_W-1:0]   div_rem;
	logic                              div_done;

	logic signed [POS_W-1:0]           nx_tx;
	logic signed [POS_W-1:0]           nx_ty;
	logic                              last_col;
	logic                              last_row;
	logic [LIMIT_W-1:0]                count_nx;
	logic                              tile_fire;
	logic                              tile_last;

	// Offsets from the grid anchor; far edges are taken one unit in
	assign diff[LANE_MIN_X] = sext(in_q.area_min_x) - sext(in_q.grid_origin_x);
	assign diff[LANE_MIN_Y] = sext(in_q.area_min_y) - sext(in_q.grid_origin_y);
	assign diff[LANE_MAX_X] = sext(in_q.area_max_x) - sext(in_q.grid_origin_x) - 22'sd1;
	assign diff[LANE_MAX_Y] = sext(in_q.area_max_y) - sext(in_q.grid_origin_y) - 22'sd1;

	// Build divider operands: magnitudes first, then scaled offsets with rounding half
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			mag[l] = diff[l][POS_W-1] ? POS_W'(-diff[l]) : POS_W'(diff[l]);
			if (cmd.start_tex) begin
				div_in[l] = {{(DIV_W-TEX_W-TEX_FRAC){1'b0}}, off_q[l], T_HALF};
			end else begin
				div_in[l] = {{(DIV_W-POS_W){1'b0}}, mag[l]};
			end
		end
	end

	ats_div #(
		.DIVISOR (TILE_SIZE),
		.REM_W   (REM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_rem || cmd.start_tex),
		.dividend (div_in),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Turn truncated remainders into floored ones
	always_comb begin
		logic [TEX_W-1:0] r_t;
		for (int l = 0; l < NUM_LANES; l++) begin
			r_t = TEX_W'(div_rem[l]);
			fmod[l] = (neg_q[l] && (r_t != '0)) ? (T_OFF - r_t) : r_t;
		end
	end

	// Tile edges and stop conditions
	assign nx_tx     = tx_q + T_POS;
	assign nx_ty     = ty_q + T_POS;
	assign last_col  = nx_tx >= sext(in_q.area_max_x);
	assign last_row  = nx_ty >= sext(in_q.area_max_y);
	assign count_nx  = count_q + 1'b1;
	assign tile_fire = cmd.emit && (!out_valid_q || out_ready);
	assign tile_last = empty_q || (count_nx == lim_q) || (last_col && last_row);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q     <= 1'b0;
			count_q     <= '0;
			col_first_q <= 1'b0;
			row_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				empty_q <= (in_data.area_max_x <= in_data.area_min_x) ||
					(in_data.area_max_y <= in_data.area_min_y) ||
					(in_data.tile_limit == '0);
				count_q <= '0;
			end
			if (cmd.cap_rem) begin
				col_first_q <= 1'b1;
				row_first_q <= 1'b1;
			end
			// Advance along the row, wrap to the next row at the far edge
			if (tile_fire && !empty_q) begin
				count_q <= count_nx;
				if (last_col) begin
					col_first_q <= 1'b1;
					row_first_q <= 1'b0;
				end else begin
					col_first_q <= 1'b0;
				end
			end
			if (tile_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q  <= in_data;
			lim_q <= (in_data.tile_limit > LIM_MAX) ? LIM_MAX : in_data.tile_limit;
		end
		if (cmd.start_rem) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				neg_q[l] <= diff[l][POS_W-1];
			end
		end
		if (cmd.cap_rem) begin
			off_q[LANE_MIN_X] <= fmod[LANE_MIN_X];
			off_q[LANE_MIN_Y] <= fmod[LANE_MIN_Y];
			off_q[LANE_MAX_X] <= fmod[LANE_MAX_X] + 1'b1;
			off_q[LANE_MAX_Y] <= fmod[LANE_MAX_Y] + 1'b1;
			first_x_q <= sext(in_q.area_min_x) - POS_W'(fmod[LANE_MIN_X]);
			first_y_q <= sext(in_q.area_min_y) - POS_W'(fmod[LANE_MIN_Y]);
			tx_q      <= sext(in_q.area_min_x) - POS_W'(fmod[LANE_MIN_X]);
			ty_q      <= sext(in_q.area_min_y) - POS_W'(fmod[LANE_MIN_Y]);
		end
		if (cmd.cap_tex) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				tex_q[l] <= TEX_W'(div_quot[l]);
			end
		end
		if (tile_fire && !empty_q) begin
			if (last_col) begin
				tx_q <= first_x_q;
				ty_q <= nx_ty;
			end else begin
				tx_q <= nx_tx;
			end
		end
		// Clip the tile to the area; only edge tiles carry partial texture spans
		if (tile_fire) begin
			if (empty_q) begin
				out_q            <= '0;
				out_q.last_tile  <= 1'b1;
				out_q.empty_area <= 1'b1;
			end else begin
				out_q.clip_x0    <= col_first_q ? in_q.area_min_x : tx_q[COORD_W-1:0];
				out_q.clip_y0    <= row_first_q ? in_q.area_min_y : ty_q[COORD_W-1:0];
				out_q.clip_x1    <= last_col ? in_q.area_max_x : nx_tx[COORD_W-1:0];
				out_q.clip_y1    <= last_row ? in_q.area_max_y : nx_ty[COORD_W-1:0];
				out_q.tex_u0     <= col_first_q ? tex_q[LANE_MIN_X] : '0;
				out_q.tex_v0     <= row_first_q ? tex_q[LANE_MIN_Y] : '0;
				out_q.tex_u1     <= last_col ? tex_q[LANE_MAX_X] : TEX_ONE;
				out_q.tex_v1     <= last_row ? tex_q[LANE_MAX_Y] : TEX_ONE;
				out_q.last_tile  <= tile_last;
				out_q.empty_area <= 1'b0;
			end
		end
	end

	assign out_data      = out_q;
	assign out_valid     = out_valid_q;
	assign sts.empty     = empty_q;
	assign sts.div_done  = div_done;
	assign sts.tile_fire = tile_fire;
	assign sts.tile_last = tile_last;

	`ATS_ASSERT_NXT(a_last_reaches_out, clk, arst_n, tile_fire && tile_last, out_valid_q && out_q.last_tile, "final tile not flagged at output")
	`ATS_ASSERT_IMP(a_empty_is_last, clk, arst_n, out_valid_q && out_q.empty_area, out_q.last_tile, "empty result without last flag")
	`ATS_ASSERT_IMP(a_within_limit, clk, arst_n, tile_fire && !empty_q, count_q < lim_q, "tile emitted beyond the limit")

endmodule

### rtl/ats_ctrl.sv
module ats_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output ats_pkg::cmd_t cmd,
	input  ats_pkg::sts_t sts
);
	import ats_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_REM   = 3'd2;
	localparam logic [2:0] S_TEXS  = 3'd3;
	localparam logic [2:0] S_TEX   = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// Sequence one item: grid corner, texture spans, then tiles
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_START;
				end
			end
			S_START: begin
				if (sts.empty) begin
					state_nx = S_EMIT;
				end else begin
					cmd.start_rem = 1'b1;
					state_nx      = S_REM;
				end
			end
			S_REM: begin
				if (sts.div_done) begin
					cmd.cap_rem = 1'b1;
					state_nx    = S_TEXS;
				end
			end
			S_TEXS: begin
				cmd.start_tex = 1'b1;
				state_nx      = S_TEX;
			end
			S_TEX: begin
				if (sts.div_done) begin
					cmd.cap_tex = 1'b1;
					state_nx    = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.tile_fire && sts.tile_last) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

### rtl/anchored_tile_splitter_top.sv
// Each input item takes two passes of the 4-lane divider (4 quotient bits per
// cycle) plus sequencing before its first tile beat; an empty area or zero limit
// skips both passes. Throughput: one tile beat per cycle while the output is not
// stalled; a new item is accepted only after the last tile of the previous one.
// Reset: arst_n low clears the controller, divider and output valid at once.
module anchored_tile_splitter_top #(
	parameter int unsigned TILE_PIXELS = 64,
	parameter int unsigned MAX_TILES   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ats_in_if.sink     in_item,
	ats_out_if.source  out_item
);
	import ats_pkg::*;

	localparam int unsigned TILE_SIZE = TILE_PIXELS * 16;
	localparam int unsigned REM_W     = $clog2(TILE_SIZE) + 1;

	cmd_t cmd;
	sts_t sts;
	in_t  in_data;
	out_t out_data;
	logic out_valid;

	// Gather the input beat
	assign in_data.area_min_x    = in_item.area_min_x;
	assign in_data.area_min_y    = in_item.area_min_y;
	assign in_data.area_max_x    = in_item.area_max_x;
	assign in_data.area_max_y    = in_item.area_max_y;
	assign in_data.grid_origin_x = in_item.grid_origin_x;
	assign in_data.grid_origin_y = in_item.grid_origin_y;
	assign in_data.tile_limit    = in_item.tile_limit;

	ats_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_ready (in_item.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ats_dp #(
		.TILE_SIZE (TILE_SIZE),
		.MAX_TILES (MAX_TILES),
		.REM_W     (REM_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_item.ready)
	);

	// Drive the output beat
	assign out_item.valid      = out_valid;
	assign out_item.clip_x0    = out_data.clip_x0;
	assign out_item.clip_y0    = out_data.clip_y0;
	assign out_item.clip_x1    = out_data.clip_x1;
	assign out_item.clip_y1    = out_data.clip_y1;
	assign out_item.tex_u0     = out_data.tex_u0;
	assign out_item.tex_v0     = out_data.tex_v0;
	assign out_item.tex_u1     = out_data.tex_u1;
	assign out_item.tex_v1     = out_data.tex_v1;
	assign out_item.last_tile  = out_data.last_tile;
	assign out_item.empty_area = out_data.empty_area;

endmodule

### bench/tile_checker.sv
module tile_checker #(
	parameter int unsigned TILE_PIXELS = 64,
	parameter int unsigned MAX_TILES   = 64
) (
	input  logic clk,
	input  logic arst_n,
	ats_in_if    in_mon,
	ats_out_if   out_mon,
	output int   mismatches,
	output int   tiles_pending
);
	import ats_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TILE_UNITS = longint'(TILE_PIXELS) * 16;
	localparam longint TEX_UNIT   = 4096;

	out_t expected_tiles[$];

	// Snap a coordinate offset down to the nearest grid line (floor, not truncate)
	function automatic longint snap_to_grid(input longint offset);
		longint q;
		q = offset / TILE_UNITS;
		if ((offset % TILE_UNITS) != 0 && offset < 0) begin
			q = q - 1;
		end
		return q * TILE_UNITS;
	endfunction

	// Position inside the tile as a 12-bit fraction, rounded half up
	function automatic logic [TEX_W-1:0] tex_pos(input longint offset);
		longint r;
		r = (offset * TEX_UNIT + TILE_UNITS / 2) / TILE_UNITS;
		if (r < 0) begin
			r = 0;
		end
		if (r > TEX_UNIT) begin
			r = TEX_UNIT;
		end
		return r[TEX_W-1:0];
	endfunction

	// Cut one area on the anchored grid and queue every tile it yields, up to the budget
	task automatic plan_area_tiles(input in_t area);
		longint min_x, min_y, max_x, max_y, org_x, org_y;
		longint corner_x, corner_y, row_y, col_x;
		longint x0, y0, x1, y1;
		int unsigned budget;
		int unsigned emitted;
		out_t tile;
		min_x = area.area_min_x;
		min_y = area.area_min_y;
		max_x = area.area_max_x;
		max_y = area.area_max_y;
		org_x = area.grid_origin_x;
		org_y = area.grid_origin_y;
		budget = area.tile_limit;
		emitted = 0;
		if (budget > MAX_TILES) begin
			budget = MAX_TILES;
		end

		// Degenerate area or zero budget: a single empty beat
		if (max_x <= min_x || max_y <= min_y || budget == 0) begin
			tile = '0;
			tile.last_tile = 1'b1;
			tile.empty_area = 1'b1;
			expected_tiles.push_back(tile);
			return;
		end

		corner_x = org_x + snap_to_grid(min_x - org_x);
		corner_y = org_y + snap_to_grid(min_y - org_y);
		for (row_y = corner_y; row_y < max_y && emitted < budget; row_y += TILE_UNITS) begin
			y0 = (row_y > min_y) ? row_y : min_y;
			y1 = (row_y + TILE_UNITS < max_y) ? row_y + TILE_UNITS : max_y;
			for (col_x = corner_x; col_x < max_x && emitted < budget;
					col_x += TILE_UNITS) begin
				x0 = (col_x > min_x) ? col_x : min_x;
				x1 = (col_x + TILE_UNITS < max_x) ? col_x + TILE_UNITS : max_x;
				tile = '0;
				tile.clip_x0 = x0[COORD_W-1:0];
				tile.clip_y0 = y0[COORD_W-1:0];
				tile.clip_x1 = x1[COORD_W-1:0];
				tile.clip_y1 = y1[COORD_W-1:0];
				tile.tex_u0 = tex_pos(x0 - col_x);
				tile.tex_v0 = tex_pos(y0 - row_y);
				tile.tex_u1 = tex_pos(x1 - col_x);
				tile.tex_v1 = tex_pos(y1 - row_y);
				expected_tiles.push_back(tile);
				emitted++;
			end
		end
		expected_tiles[expected_tiles.size() - 1].last_tile = 1'b1;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		tiles_pending = 0;
	end

	// Predict on each area beat, then compare each tile beat with the oldest tile
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready) begin
				in_t area;
				area.area_min_x = in_mon.area_min_x;
				area.area_min_y = in_mon.area_min_y;
				area.area_max_x = in_mon.area_max_x;
				area.area_max_y = in_mon.area_max_y;
				area.grid_origin_x = in_mon.grid_origin_x;
				area.grid_origin_y = in_mon.grid_origin_y;
				area.tile_limit = in_mon.tile_limit;
				plan_area_tiles(area);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_tiles.size() == 0) begin
					$error("tile beat with no tile expected");
					mismatches++;
				end else begin
					want = expected_tiles.pop_front();
					check_field("clip_x0", want.clip_x0, out_mon.clip_x0);
					check_field("clip_y0", want.clip_y0, out_mon.clip_y0);
					check_field("clip_x1", want.clip_x1, out_mon.clip_x1);
					check_field("clip_y1", want.clip_y1, out_mon.clip_y1);
					check_field("tex_u0", want.tex_u0, out_mon.tex_u0);
					check_field("tex_v0", want.tex_v0, out_mon.tex_v0);
					check_field("tex_u1", want.tex_u1, out_mon.tex_u1);
					check_field("tex_v1", want.tex_v1, out_mon.tex_v1);
					check_field("last_tile", want.last_tile, out_mon.last_tile);
					check_field("empty_area", want.empty_area, out_mon.empty_area);
				end
			end
			tiles_pending = expected_tiles.size();
		end
	end

endmodule

### bench/testbench.sv
module testbench;
	import ats_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TILE_PIXELS = 64;
	localparam int unsigned MAX_TILES   = 64;
	localparam longint      TILE_UNITS  = longint'(TILE_PIXELS) * 16;
	localparam int          RANDOM_AREAS = 250;
	localparam int          CALM_AREAS   = 40;
	localparam int          STALL_LIMIT  = 3000;
	localparam int          DRAIN_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic calm;
	int   mismatches;
	int   tiles_pending;

	ats_in_if  in_item();
	ats_out_if out_item();

	anchored_tile_splitter_top #(
		.TILE_PIXELS(TILE_PIXELS),
		.MAX_TILES  (MAX_TILES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.out_item(out_item)
	);

	tile_checker #(
		.TILE_PIXELS(TILE_PIXELS),
		.MAX_TILES  (MAX_TILES)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mon       (in_item),
		.out_mon      (out_item),
		.mismatches   (mismatches),
		.tiles_pending(tiles_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic longint rand_coord();
		logic signed [COORD_W-1:0] v;
		v = $urandom;
		return v;
	endfunction

	// Build an area from its corner and size; the far edge wraps at 20 bits
	function automatic in_t make_area(input longint x0, input longint y0, input longint w,
			input longint h, input longint ox, input longint oy, input int lim);
		in_t a;
		longint x1, y1;
		x1 = x0 + w;
		y1 = y0 + h;
		a.area_min_x = x0[COORD_W-1:0];
		a.area_min_y = y0[COORD_W-1:0];
		a.area_max_x = x1[COORD_W-1:0];
		a.area_max_y = y1[COORD_W-1:0];
		a.grid_origin_x = ox[COORD_W-1:0];
		a.grid_origin_y = oy[COORD_W-1:0];
		a.tile_limit = lim[LIMIT_W-1:0];
		return a;
	endfunction

	// Mostly well-formed areas a few tiles wide, plus noise and empty ones
	function automatic in_t random_area();
		int kind;
		longint x0, y0, w, h, ox, oy, span;
		int lim;
		kind = $urandom_range(0, 99);
		x0 = rand_coord();
		y0 = rand_coord();
		span = ($urandom_range(0, 7) == 0) ? 9 * TILE_UNITS : 4 * TILE_UNITS;
		w = $urandom_range(1, span);
		h = $urandom_range(1, span);
		if ($urandom_range(0, 1) == 0) begin
			ox = rand_coord();
			oy = rand_coord();
		end else begin
			ox = x0 - $urandom_range(0, 3 * TILE_UNITS);
			oy = y0 + $urandom_range(0, 3 * TILE_UNITS);
		end
		lim = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
		if (kind < 15) begin
			return make_area(x0, y0, rand_coord() - x0, rand_coord() - y0,
				rand_coord(), rand_coord(), $urandom_range(0, 127));
		end
		if (kind < 22) begin
			lim = 0;
		end else if (kind < 26) begin
			w = -$urandom_range(0, 2 * TILE_UNITS);
		end else if (kind < 30) begin
			h = -$urandom_range(0, 2 * TILE_UNITS);
		end
		return make_area(x0, y0, w, h, ox, oy, lim);
	endfunction

	// Present one area and hold it until accepted, then maybe idle
	task automatic send_area(input in_t a);
		in_item.valid <= 1'b1;
		in_item.area_min_x <= a.area_min_x;
		in_item.area_min_y <= a.area_min_y;
		in_item.area_max_x <= a.area_max_x;
		in_item.area_max_y <= a.area_max_y;
		in_item.grid_origin_x <= a.grid_origin_x;
		in_item.grid_origin_y <= a.grid_origin_y;
		in_item.tile_limit <= a.tile_limit;
		@(posedge clk);
		while (!in_item.ready) @(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_item.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Stall the tile side in random bursts until the calm tail
	initial begin
		out_item.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_item.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_item.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Abort when neither channel moves a beat for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		calm = 1'b0;
		arst_n <= 1'b0;
		in_item.valid <= 1'b0;
		in_item.area_min_x <= '0;
		in_item.area_min_y <= '0;
		in_item.area_max_x <= '0;
		in_item.area_max_y <= '0;
		in_item.grid_origin_x <= '0;
		in_item.grid_origin_y <= '0;
		in_item.tile_limit <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one tile, aligned tile, grid straddles, negative anchors
		send_area(make_area(100, 200, 300, 400, 0, 0, 4));
		send_area(make_area(0, 0, TILE_UNITS, TILE_UNITS, 0, 0, 8));
		send_area(make_area(-1500, -2100, 2500, 1900, 37, -5, 64));
		send_area(make_area(-3, -3, 2 * TILE_UNITS, TILE_UNITS, -1, -2, 10));
		send_area(make_area(5, 5, 2 * TILE_UNITS - 5, 2 * TILE_UNITS - 5, 5, 5, 20));
		// Directed: degenerate areas and zero budget
		send_area(make_area(1000, 1000, 0, 500, 0, 0, 5));
		send_area(make_area(1000, 1000, 500, -1, 0, 0, 5));
		send_area(make_area(1000, 1000, 500, 500, 0, 0, 0));
		send_area(make_area(-524288, -524288, 0, 0, 0, 0, 127));
		// Directed: budget cuts a row short, exact cap, saturation above the cap
		send_area(make_area(0, 0, 5 * TILE_UNITS, 5 * TILE_UNITS, 0, 0, 1));
		send_area(make_area(0, 0, 5 * TILE_UNITS, 5 * TILE_UNITS, 0, 0, 7));
		send_area(make_area(17, 33, 9 * TILE_UNITS, 9 * TILE_UNITS, 3, 11, 64));
		send_area(make_area(-900, 700, 9 * TILE_UNITS, 9 * TILE_UNITS, 0, 0, 65));
		send_area(make_area(-900, 700, 9 * TILE_UNITS, 9 * TILE_UNITS, 0, 0, 127));
		// Directed: full coordinate span with anchors far outside the area
		send_area(make_area(-524288, -524288, 1048575, 1048575, 524287, 524287, 64));
		send_area(make_area(-524288, -524288, 1048575, 1048575, -524288, -524288, 127));
		send_area(make_area(524000, 524000, 287, 287, -524288, -524288, 3));
		send_area(make_area(-524288, 524280, 2000, 7, 524287, -524288, 9));
		// Directed: fractional edges and one-unit slivers
		send_area(make_area(7, 9, 1, 1, 0, 0, 2));
		send_area(make_area(TILE_UNITS - 1, TILE_UNITS - 1, 2, 2, 0, 0, 4));
		send_area(make_area(-TILE_UNITS, 0, TILE_UNITS, 3 * TILE_UNITS + 9, 0, 0, 64));

		for (int i = 0; i < RANDOM_AREAS; i++) begin
			if (i == RANDOM_AREAS - CALM_AREAS) begin
				calm = 1'b1;
			end
			send_area(random_area());
		end
		in_item.valid <= 1'b0;

		// Drain the remaining tiles, then watch for strays
		@(posedge clk);
		while (tiles_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && tiles_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
